// ----- src/iceupe_pkg.sv -----
`default_nettype none

package iceupe_pkg;

   localparam int unsigned LENGTH_BITS = 16;
   localparam int unsigned CMP_BITS    = LENGTH_BITS + 1;
   localparam int unsigned SUM_BITS    = 9;

   typedef logic [LENGTH_BITS-1:0] pos_type;
   typedef logic [CMP_BITS-1:0]    cmp_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic [5:0]             hdr_len_type;

   localparam pos_type POS_MAX = {LENGTH_BITS{1'b1}};

   localparam logic FAMILY_IPV4 = 1'b0;
   localparam logic FAMILY_IPV6 = 1'b1;

   localparam logic KIND_TIME_EXCEEDED = 1'b0;
   localparam logic KIND_UNREACHABLE   = 1'b1;

   localparam logic [7:0] V4_TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] V4_TYPE_UNREACHABLE   = 8'd3;
   localparam logic [7:0] V4_CODE_PORT          = 8'd3;
   localparam logic [7:0] V6_TYPE_TIME_EXCEEDED = 8'd3;
   localparam logic [7:0] V6_TYPE_UNREACHABLE   = 8'd1;
   localparam logic [7:0] V6_CODE_PORT          = 8'd4;

   localparam logic [3:0] IHL_MASK = 4'hf;

   localparam sum_type ICMP_HDR_LEN   = 9'd8;
   localparam sum_type V4_MIN_LEN     = 9'd20;
   localparam sum_type V4_ICMP_SPAN   = 9'd28;
   localparam sum_type V4_INNER_SPAN  = 9'd16;
   localparam sum_type V6_MIN_LEN     = 9'd56;
   localparam sum_type V6_PORT_OFFSET = 9'd48;
   localparam sum_type V6_CODE_POS    = 9'd1;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic        reply_kind;
      logic        port_unreachable;
      logic [15:0] source_port;
      logic [15:0] dst_port;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/icmp_error_udp_port_extractor_unit.sv -----
// rsp_valid rises in the cycle after the transaction carrying the last byte.
// Throughput: one byte per cycle while req_stall is low; every byte is parsed in the cycle it is taken.
// req_stall rises only while a held result is stalled on the response side.
// Synchronous active-high reset clears the parse state, the family register
// (IPv4) and the output valid.
`default_nettype none

module icmp_error_udp_port_extractor_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire iceupe_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output iceupe_pkg::rsp_type      rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data
);

   logic                    family_ff;
   iceupe_pkg::pos_type     pos_ff, pos_in;
   iceupe_pkg::hdr_len_type outer_ff, outer_in;
   iceupe_pkg::hdr_len_type inner_ff, inner_in;
   logic [7:0]              type_ff, type_in;
   logic [7:0]              code_ff, code_in;
   logic [15:0]             src_ff, src_in;
   logic [15:0]             dst_ff, dst_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   iceupe_pkg::rsp_type     rsp_ff, rsp_in;

   logic                    accept;
   logic                    live;
   iceupe_pkg::cmp_type     pos_c;
   iceupe_pkg::cmp_type     len_c;
   iceupe_pkg::sum_type     base;
   iceupe_pkg::sum_type     type_pos;
   logic                    ok;
   logic                    kind;
   logic                    pu;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      pos_in       = pos_ff;
      outer_in     = outer_ff;
      inner_in     = inner_ff;
      type_in      = type_ff;
      code_in      = code_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      live         = pos_ff != iceupe_pkg::POS_MAX;
      pos_c        = iceupe_pkg::cmp_type'(pos_ff);
      base         = iceupe_pkg::V6_PORT_OFFSET;
      type_pos     = '0;
      ok           = 1'b0;
      kind         = iceupe_pkg::KIND_TIME_EXCEEDED;
      pu           = 1'b0;

      if (accept && live) begin
         if (family_ff == iceupe_pkg::FAMILY_IPV4) begin
            if (pos_ff == '0) begin
               outer_in = {req_data.packet_byte[3:0] & iceupe_pkg::IHL_MASK, 2'b00};
            end
            type_pos = iceupe_pkg::sum_type'(outer_in);
            if (pos_c == iceupe_pkg::cmp_type'(type_pos)) begin
               type_in = req_data.packet_byte;
            end
            if (pos_c == iceupe_pkg::cmp_type'(type_pos + 9'd1)) begin
               code_in = req_data.packet_byte;
            end
            if (pos_c == iceupe_pkg::cmp_type'(type_pos + iceupe_pkg::ICMP_HDR_LEN)) begin
               inner_in = {req_data.packet_byte[3:0] & iceupe_pkg::IHL_MASK, 2'b00};
            end
            base = type_pos + iceupe_pkg::ICMP_HDR_LEN + iceupe_pkg::sum_type'(inner_in);
         end else begin
            if (pos_ff == '0) begin
               type_in = req_data.packet_byte;
            end
            if (pos_c == iceupe_pkg::cmp_type'(iceupe_pkg::V6_CODE_POS)) begin
               code_in = req_data.packet_byte;
            end
         end
         if (pos_c == iceupe_pkg::cmp_type'(base)) begin
            src_in[15:8] = req_data.packet_byte;
         end
         if (pos_c == iceupe_pkg::cmp_type'(base + 9'd1)) begin
            src_in[7:0] = req_data.packet_byte;
         end
         if (pos_c == iceupe_pkg::cmp_type'(base + 9'd2)) begin
            dst_in[15:8] = req_data.packet_byte;
         end
         if (pos_c == iceupe_pkg::cmp_type'(base + 9'd3)) begin
            dst_in[7:0] = req_data.packet_byte;
         end
         pos_in = pos_ff + iceupe_pkg::pos_type'(1);
      end

      // end-of-packet checks use the state including the last byte
      len_c = iceupe_pkg::cmp_type'(pos_in);
      if (family_ff == iceupe_pkg::FAMILY_IPV4) begin
         ok = len_c >= iceupe_pkg::cmp_type'(iceupe_pkg::V4_MIN_LEN)
            && len_c >= iceupe_pkg::cmp_type'(iceupe_pkg::sum_type'(outer_in)
                                                + iceupe_pkg::V4_ICMP_SPAN)
            && len_c >= iceupe_pkg::cmp_type'(iceupe_pkg::sum_type'(outer_in)
                                                + iceupe_pkg::sum_type'(inner_in)
                                                + iceupe_pkg::V4_INNER_SPAN)
            && (type_in == iceupe_pkg::V4_TYPE_TIME_EXCEEDED
                || type_in == iceupe_pkg::V4_TYPE_UNREACHABLE);
         kind = (type_in == iceupe_pkg::V4_TYPE_TIME_EXCEEDED)
              ? iceupe_pkg::KIND_TIME_EXCEEDED : iceupe_pkg::KIND_UNREACHABLE;
         pu   = type_in == iceupe_pkg::V4_TYPE_UNREACHABLE
              && code_in == iceupe_pkg::V4_CODE_PORT;
      end else begin
         ok   = len_c >= iceupe_pkg::cmp_type'(iceupe_pkg::V6_MIN_LEN)
              && (type_in == iceupe_pkg::V6_TYPE_TIME_EXCEEDED
                  || type_in == iceupe_pkg::V6_TYPE_UNREACHABLE);
         kind = (type_in == iceupe_pkg::V6_TYPE_TIME_EXCEEDED)
              ? iceupe_pkg::KIND_TIME_EXCEEDED : iceupe_pkg::KIND_UNREACHABLE;
         pu   = type_in == iceupe_pkg::V6_TYPE_UNREACHABLE
              && code_in == iceupe_pkg::V6_CODE_PORT;
      end

      if (accept && req_data.last_byte) begin
         rsp_valid_in            = 1'b1;
         rsp_in.found            = ok;
         rsp_in.reply_kind       = ok && kind;
         rsp_in.port_unreachable = ok && pu;
         rsp_in.source_port      = ok ? src_in : 16'd0;
         rsp_in.dst_port         = ok ? dst_in : 16'd0;
         pos_in   = '0;
         outer_in = '0;
         inner_in = '0;
         type_in  = '0;
         code_in  = '0;
         src_in   = '0;
         dst_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff    <= iceupe_pkg::FAMILY_IPV4;
         pos_ff       <= '0;
         outer_ff     <= '0;
         inner_ff     <= '0;
         type_ff      <= '0;
         code_ff      <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            family_ff <= csr_wr_data;
         end
         pos_ff       <= pos_in;
         outer_ff     <= outer_in;
         inner_ff     <= inner_in;
         type_ff      <= type_in;
         code_ff      <= code_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire
